@@ hdl/rbh_pkg.sv @@
// ----------------------------------------------------------------------------
// rbh_pkg
// shared constants and register codes for the rounded border hit test
// ----------------------------------------------------------------------------
package rbh_pkg;

  localparam int COORD_BITS = 16;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RECT_WIDTH       = 3'd0,
    REG_RECT_HEIGHT      = 3'd1,
    REG_BORDER_THICKNESS = 3'd2,
    REG_RADIUS_TL        = 3'd3,
    REG_RADIUS_TR        = 3'd4,
    REG_RADIUS_BR        = 3'd5,
    REG_RADIUS_BL        = 3'd6
  } reg_idx_t;

endpackage

@@ hdl/rbh_shape_sel.sv @@
// ----------------------------------------------------------------------------
// rbh_shape_sel
// bounds check and corner selection for one rounded rectangle; all lengths
// doubled, radii already clamped
// ----------------------------------------------------------------------------
module rbh_shape_sel #(
  parameter int CW = rbh_pkg::COORD_BITS
) (
  input  logic signed [CW+3:0] px,
  input  logic signed [CW+3:0] py,
  input  logic signed [CW+3:0] wd,
  input  logic signed [CW+3:0] ht,
  input  logic        [CW-1:0] r_tl,
  input  logic        [CW-1:0] r_tr,
  input  logic        [CW-1:0] r_br,
  input  logic        [CW-1:0] r_bl,
  output logic                 in_bounds,
  output logic                 round,
  output logic        [CW-1:0] adx,
  output logic        [CW-1:0] ady,
  output logic        [CW-1:0] rad
);

  localparam int XW = CW + 4;

  logic signed [XW-1:0] rtl, rtr, rbr, rbl;
  logic signed [XW-1:0] dx, dy, ax, ay;
  logic        [CW-1:0] rsel;

  assign rtl = $signed({{(XW-CW){1'b0}}, r_tl});
  assign rtr = $signed({{(XW-CW){1'b0}}, r_tr});
  assign rbr = $signed({{(XW-CW){1'b0}}, r_br});
  assign rbl = $signed({{(XW-CW){1'b0}}, r_bl});

  assign in_bounds = !(px < 0 || py < 0 || px > wd || py > ht);

  always_comb begin
    round = 1'b1;
    dx    = '0;
    dy    = '0;
    rsel  = '0;
    if (px < rtl && py < rtl && r_tl != '0) begin
      dx   = px - rtl;
      dy   = py - rtl;
      rsel = r_tl;
    end else if (px > wd - rtr && py < rtr && r_tr != '0) begin
      dx   = px - (wd - rtr);
      dy   = py - rtr;
      rsel = r_tr;
    end else if (px > wd - rbr && py > ht - rbr && r_br != '0) begin
      dx   = px - (wd - rbr);
      dy   = py - (ht - rbr);
      rsel = r_br;
    end else if (px < rbl && py > ht - rbl && r_bl != '0) begin
      dx   = px - rbl;
      dy   = py - (ht - rbl);
      rsel = r_bl;
    end else begin
      round = 1'b0;
    end
  end

  assign ax  = dx[XW-1] ? -dx : dx;
  assign ay  = dy[XW-1] ? -dy : dy;
  assign adx = ax[CW-1:0];
  assign ady = ay[CW-1:0];
  assign rad = rsel;

endmodule

@@ hdl/rounded_border_hit_test_top.sv @@
// ----------------------------------------------------------------------------
// rounded_border_hit_test_top
// tests whether a signed fixed point coordinate lies on the ring of a
// rounded-rectangle border
// ----------------------------------------------------------------------------
// usage:
//   configuration: write size, thickness and four corner radii through the
//   cfg_ channel (cfg_ready is always high) while no transaction is in flight
//   input: a transaction is taken at each clock edge with start high and busy
//   low; busy is high during reset and in the first cycle after it
//   output: out_valid is high for one cycle with out_on_border; the result
//   passes the stage 0, 1, 2 and 3 registers after the accepting edge
//   throughput: one point per clock while busy is low, set by the four-stage
//   pipeline (select corner, square, compare); the receiver cannot stall and none is needed
//   reset: clears the configuration to zero and empties the pipeline
// ----------------------------------------------------------------------------
module rounded_border_hit_test_top #(
  parameter int COORD_BITS = rbh_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x_pos,
  input  logic signed [COORD_BITS-1:0] in_y_pos,
  output logic                         out_valid,
  output logic                         out_on_border,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rbh_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int XW = CW + 4;

  logic [CW-1:0] width_r, height_r, thick_r;
  logic [CW-1:0] rad_r [4];

  // derived configuration
  logic [CW-1:0] lim;
  logic [CW-1:0] tmin;
  logic [CW:0]   t2_nxt, t2_r;
  logic [CW-1:0] orad_nxt [4];
  logic [CW-1:0] orad_r   [4];
  logic [CW-1:0] irad_nxt [4];
  logic [CW-1:0] irad_r   [4];
  logic [CW:0]   iw_nxt, ih_nxt, iw_r, ih_r;
  logic          empty_nxt, empty_r;

  logic          busy_r;

  // stage 0
  logic                  s0_v_r;
  logic signed [CW-1:0]  s0_x_r, s0_y_r;

  // stage 1
  logic signed [XW-1:0]  ox, oy, ix, iy, ow, oh, iwe, ihe;
  logic                  o_in, o_rnd, i_in, i_rnd;
  logic [CW-1:0]         o_dx, o_dy, o_rad, i_dx, i_dy, i_rad;
  logic                  s1_v_r, s1_tnz_r, s1_empty_r;
  logic                  s1_oin_r, s1_ornd_r, s1_iin_r, s1_irnd_r;
  logic [CW-1:0]         s1_odx_r, s1_ody_r, s1_orad_r;
  logic [CW-1:0]         s1_idx_r, s1_idy_r, s1_irad_r;

  // stage 2
  logic                  s2_v_r, s2_tnz_r, s2_empty_r;
  logic                  s2_oin_r, s2_ornd_r, s2_iin_r, s2_irnd_r;
  logic [2*CW-1:0]       s2_odx_r, s2_ody_r, s2_orad_r;
  logic [2*CW-1:0]       s2_idx_r, s2_idy_r, s2_irad_r;

  // stage 3
  logic [2*CW:0]         o_sum, i_sum;
  logic                  o_hit, i_hit, hit_nxt;
  logic                  out_valid_r, on_border_r;

  logic                  accept;

  assign accept    = start && !busy;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      thick_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        rad_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbh_pkg::REG_RECT_WIDTH:       width_r  <= cfg_data;
        rbh_pkg::REG_RECT_HEIGHT:      height_r <= cfg_data;
        rbh_pkg::REG_BORDER_THICKNESS: thick_r  <= cfg_data;
        rbh_pkg::REG_RADIUS_TL:        rad_r[0] <= cfg_data;
        rbh_pkg::REG_RADIUS_TR:        rad_r[1] <= cfg_data;
        rbh_pkg::REG_RADIUS_BR:        rad_r[2] <= cfg_data;
        rbh_pkg::REG_RADIUS_BL:        rad_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // half the smaller doubled side equals the smaller raw side
  always_comb begin
    lim       = (width_r < height_r) ? width_r : height_r;
    tmin      = (thick_r < lim) ? thick_r : lim;
    t2_nxt    = {tmin, 1'b0};
    empty_nxt = ({1'b0, width_r} <= t2_nxt) || ({1'b0, height_r} <= t2_nxt);
    iw_nxt    = {width_r, 1'b0} - {t2_nxt[CW-1:0], 1'b0};
    ih_nxt    = {height_r, 1'b0} - {t2_nxt[CW-1:0], 1'b0};
    for (int i = 0; i < 4; i++) begin
      orad_nxt[i] = ({rad_r[i], 1'b0} < {1'b0, lim}) ? {rad_r[i][CW-2:0], 1'b0} : lim;
      irad_nxt[i] = ({1'b0, orad_nxt[i]} > t2_nxt) ?
                    orad_nxt[i] - t2_nxt[CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    t2_r    <= t2_nxt;
    empty_r <= empty_nxt;
    iw_r    <= iw_nxt;
    ih_r    <= ih_nxt;
    for (int i = 0; i < 4; i++) begin
      orad_r[i] <= orad_nxt[i];
      irad_r[i] <= irad_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_x_r <= in_x_pos;
      s0_y_r <= in_y_pos;
    end
  end

  // stage 1: bounds and corner selection
  assign ox  = {{3{s0_x_r[CW-1]}}, s0_x_r, 1'b0};
  assign oy  = {{3{s0_y_r[CW-1]}}, s0_y_r, 1'b0};
  assign ow  = {3'b000, width_r, 1'b0};
  assign oh  = {3'b000, height_r, 1'b0};
  assign ix  = ox - $signed({3'b000, t2_r});
  assign iy  = oy - $signed({3'b000, t2_r});
  assign iwe = $signed({3'b000, iw_r});
  assign ihe = $signed({3'b000, ih_r});

  rbh_shape_sel #(.CW(CW)) u_outer (
    .px(ox), .py(oy), .wd(ow), .ht(oh),
    .r_tl(orad_r[0]), .r_tr(orad_r[1]), .r_br(orad_r[2]), .r_bl(orad_r[3]),
    .in_bounds(o_in), .round(o_rnd), .adx(o_dx), .ady(o_dy), .rad(o_rad)
  );

  rbh_shape_sel #(.CW(CW)) u_inner (
    .px(ix), .py(iy), .wd(iwe), .ht(ihe),
    .r_tl(irad_r[0]), .r_tr(irad_r[1]), .r_br(irad_r[2]), .r_bl(irad_r[3]),
    .in_bounds(i_in), .round(i_rnd), .adx(i_dx), .ady(i_dy), .rad(i_rad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tnz_r   <= (t2_r != '0);
    s1_empty_r <= empty_r;
    s1_oin_r   <= o_in;
    s1_ornd_r  <= o_rnd;
    s1_iin_r   <= i_in;
    s1_irnd_r  <= i_rnd;
    s1_odx_r   <= o_dx;
    s1_ody_r   <= o_dy;
    s1_orad_r  <= o_rad;
    s1_idx_r   <= i_dx;
    s1_idy_r   <= i_dy;
    s1_irad_r  <= i_rad;
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_tnz_r   <= s1_tnz_r;
    s2_empty_r <= s1_empty_r;
    s2_oin_r   <= s1_oin_r;
    s2_ornd_r  <= s1_ornd_r;
    s2_iin_r   <= s1_iin_r;
    s2_irnd_r  <= s1_irnd_r;
    s2_odx_r   <= {{CW{1'b0}}, s1_odx_r} * {{CW{1'b0}}, s1_odx_r};
    s2_ody_r   <= {{CW{1'b0}}, s1_ody_r} * {{CW{1'b0}}, s1_ody_r};
    s2_orad_r  <= {{CW{1'b0}}, s1_orad_r} * {{CW{1'b0}}, s1_orad_r};
    s2_idx_r   <= {{CW{1'b0}}, s1_idx_r} * {{CW{1'b0}}, s1_idx_r};
    s2_idy_r   <= {{CW{1'b0}}, s1_idy_r} * {{CW{1'b0}}, s1_idy_r};
    s2_irad_r  <= {{CW{1'b0}}, s1_irad_r} * {{CW{1'b0}}, s1_irad_r};
  end

  // stage 3: distance compare and ring decision
  always_comb begin
    o_sum   = {1'b0, s2_odx_r} + {1'b0, s2_ody_r};
    i_sum   = {1'b0, s2_idx_r} + {1'b0, s2_idy_r};
    o_hit   = s2_oin_r && (!s2_ornd_r || o_sum <= {1'b0, s2_orad_r});
    i_hit   = s2_iin_r && (!s2_irnd_r || i_sum <= {1'b0, s2_irad_r});
    hit_nxt = s2_tnz_r && o_hit && (s2_empty_r || !i_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    on_border_r <= hit_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_on_border = on_border_r;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("transaction without result");

  a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result without transaction");

  a_busy_empty : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid && !s0_v_r)
    else $error("pipeline not empty while busy");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rounded-rectangle border hit test: configures
// size, thickness and corner radii, sends points with random gaps and checks
// each on_border answer against a local model of the ring geometry
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_REGS = 7;
  localparam logic [rbh_pkg::REG_IDX_W-1:0] REG_IDX_UNUSED = 3'd7;
  localparam int PIPE_LATENCY = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef logic [rbh_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [rbh_pkg::COORD_BITS-1:0] scoord_t;

  typedef struct {
    scoord_t x;
    scoord_t y;
    bit hit;
  } border_expect_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  scoord_t in_x_pos;
  scoord_t in_y_pos;
  logic out_valid;
  logic out_on_border;
  logic cfg_valid;
  logic cfg_ready;
  logic [rbh_pkg::REG_IDX_W-1:0] cfg_index;
  coord_t cfg_data;

  coord_t shape_reg [NUM_REGS];
  border_expect_t pending_hits [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit no_gaps = 0;

  rounded_border_hit_test_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_x_pos(in_x_pos),
    .in_y_pos(in_y_pos),
    .out_valid(out_valid),
    .out_on_border(out_on_border),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ring geometry, all lengths doubled
  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit in_circle(longint dx, longint dy, longint r);
    return (dx * dx + dy * dy) <= (r * r);
  endfunction

  function automatic bit in_rounded_shape(longint w, longint h, longint rad [4],
                                          longint x, longint y);
    longint lim;
    longint r [4];
    if (x < 0 || y < 0 || x > w || y > h) return 1'b0;
    lim = lmin(w, h) / 2;
    for (int i = 0; i < 4; i++) r[i] = lmin(rad[i], lim);
    if (x < r[0] && y < r[0] && r[0] > 0)
      return in_circle(x - r[0], y - r[0], r[0]);
    if (x > w - r[1] && y < r[1] && r[1] > 0)
      return in_circle(x - (w - r[1]), y - r[1], r[1]);
    if (x > w - r[2] && y > h - r[2] && r[2] > 0)
      return in_circle(x - (w - r[2]), y - (h - r[2]), r[2]);
    if (x < r[3] && y > h - r[3] && r[3] > 0)
      return in_circle(x - r[3], y - (h - r[3]), r[3]);
    return 1'b1;
  endfunction

  function automatic bit predict_on_border(scoord_t xp, scoord_t yp);
    longint w, h, t, x, y, lim;
    longint outer [4];
    longint inner [4];
    w = 2 * longint'(shape_reg[rbh_pkg::REG_RECT_WIDTH]);
    h = 2 * longint'(shape_reg[rbh_pkg::REG_RECT_HEIGHT]);
    t = lmin(2 * longint'(shape_reg[rbh_pkg::REG_BORDER_THICKNESS]), lmin(w, h));
    x = 2 * longint'(xp);
    y = 2 * longint'(yp);
    lim = lmin(w, h) / 2;
    for (int i = 0; i < 4; i++) begin
      outer[i] = 2 * longint'(shape_reg[rbh_pkg::REG_RADIUS_TL + i]);
      inner[i] = lmin(outer[i], lim) - t;
      if (inner[i] < 0) inner[i] = 0;
    end
    if (t <= 0) return 1'b0;
    if (!in_rounded_shape(w, h, outer, x, y)) return 1'b0;
    if (w - 2 * t <= 0 || h - 2 * t <= 0) return 1'b1;
    return !in_rounded_shape(w - 2 * t, h - 2 * t, inner, x - t, y - t);
  endfunction

  // result checker
  always @(posedge clk) begin
    border_expect_t exp_item;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected transaction: on_border=%0b", out_on_border);
      end else begin
        exp_item = pending_hits.pop_front();
        if (out_on_border !== exp_item.hit) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at (%0d, %0d): on_border expected %0b actual %0b",
                     exp_item.x, exp_item.y, exp_item.hit, out_on_border);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_point(input scoord_t xp, input scoord_t yp);
    int gap;
    border_expect_t item;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_x_pos = xp;
    in_y_pos = yp;
    do @(posedge clk); while (busy);
    item.x = xp;
    item.y = yp;
    item.hit = predict_on_border(xp, yp);
    pending_hits.push_back(item);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rbh_pkg::REG_IDX_W-1:0] idx,
                           input coord_t value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) shape_reg[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_shape(input int w, input int h, input int t,
                           input int tl, input int tr, input int br, input int bl);
    wait_drained();
    write_reg(rbh_pkg::REG_RECT_WIDTH, coord_t'(w));
    write_reg(rbh_pkg::REG_RECT_HEIGHT, coord_t'(h));
    write_reg(rbh_pkg::REG_BORDER_THICKNESS, coord_t'(t));
    write_reg(rbh_pkg::REG_RADIUS_TL, coord_t'(tl));
    write_reg(rbh_pkg::REG_RADIUS_TR, coord_t'(tr));
    write_reg(rbh_pkg::REG_RADIUS_BR, coord_t'(br));
    write_reg(rbh_pkg::REG_RADIUS_BL, coord_t'(bl));
  endtask

  function automatic scoord_t to_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return scoord_t'(v);
  endfunction

  function automatic int near_span(int span);
    return int'($urandom_range(0, span + 8)) - 4;
  endfunction

  function automatic int edge_band(int span, int t);
    int off;
    off = $urandom_range(0, ((t < span) ? t : span) + 3);
    return ($urandom_range(0, 1) != 0) ? off - 2 : span - off + 2;
  endfunction

  task automatic random_point(output scoord_t xp, output scoord_t yp);
    int w, h, t;
    w = int'(shape_reg[rbh_pkg::REG_RECT_WIDTH]);
    h = int'(shape_reg[rbh_pkg::REG_RECT_HEIGHT]);
    t = int'(shape_reg[rbh_pkg::REG_BORDER_THICKNESS]);
    case ($urandom_range(0, 9))
      0, 1: begin
        xp = scoord_t'($urandom);
        yp = scoord_t'($urandom);
      end
      2, 3, 4: begin
        xp = to_coord(near_span(w));
        yp = to_coord(near_span(h));
      end
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          xp = to_coord(edge_band(w, t));
          yp = to_coord(near_span(h));
        end else begin
          xp = to_coord(near_span(w));
          yp = to_coord(edge_band(h, t));
        end
      end
    endcase
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 400);
    if (r < 90) return $urandom_range(0, 65535);
    return ($urandom_range(0, 1) != 0) ? 65535 : 0;
  endfunction

  function automatic int rand_thickness();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 60);
    if (r < 95) return $urandom_range(0, 65535);
    return 65535;
  endfunction

  function automatic int rand_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 85) return $urandom_range(1, 200);
    return ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 65535);
  endfunction

  task automatic test_reset_state();
    send_point(0, 0);
    send_point(16'sh7fff, 16'sh8000);
  endtask

  task automatic test_edges_and_corners();
    set_shape(160, 96, 16, 32, 0, 200, 8);
    send_point(0, 0);
    send_point(32, 0);
    send_point(80, 0);
    send_point(80, 48);
    send_point(160, 48);
    send_point(161, 48);
    send_point(80, -1);
    send_point(0, 48);
    send_point(160, 0);
    send_point(160, 96);
    send_point(0, 96);
    send_point(8, 96);
    send_point(80, 16);
    send_point(80, 15);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_special_shapes();
    // zero thickness
    set_shape(160, 96, 0, 32, 0, 200, 8);
    send_point(0, 48);
    // inner rectangle empty
    set_shape(160, 96, 48, 32, 0, 200, 8);
    send_point(80, 48);
    // zero-sized rectangle
    set_shape(0, 0, 5, 0, 0, 0, 0);
    send_point(0, 0);
    send_point(1, 0);
    // write to an unused register index is dropped
    wait_drained();
    write_reg(REG_IDX_UNUSED, 16'hffff);
    send_point(0, 0);
  endtask

  task automatic test_extreme_registers();
    set_shape(65535, 65535, 65535, 65535, 65535, 65535, 65535);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(0, 0);
    send_point(0, 16'sh7fff);
    set_shape(65535, 40, 3, 65535, 0, 7, 65535);
    send_point(16'sh7fff, 20);
    send_point(20, 1);
  endtask

  task automatic test_random_shapes();
    scoord_t xp, yp;
    for (int phase = 0; phase < 8; phase++) begin
      set_shape(rand_size(), rand_size(), rand_thickness(),
                rand_radius(), rand_radius(), rand_radius(), rand_radius());
      no_gaps = (phase == 3);
      for (int n = 0; n < 55; n++) begin
        if (phase == 2 && n == 25) wait_drained();
        random_point(xp, yp);
        send_point(xp, yp);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_x_pos = '0;
    in_y_pos = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NUM_REGS; i++) shape_reg[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_edges_and_corners();
    test_special_shapes();
    test_extreme_registers();
    test_random_shapes();

    wait_drained();
    if (mismatch_count == 0 && pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rbh_pkg.sv
hdl/rbh_shape_sel.sv
hdl/rounded_border_hit_test_top.sv
tb/sv/tb.sv
